/* sv/trc_pkg.sv */
package trc_pkg;

   localparam int VEC_W = 63;
   localparam int REQ_W = 320;
   localparam int RSP_W = 128;
   localparam int UNIT_BITS = 30;
   localparam int MAG_W = UNIT_BITS;
   localparam int SUM_W = 2 * MAG_W + 2;
   localparam int ROOT_W = MAG_W + 1;
   localparam int QUOT_W = MAG_W + 1;
   localparam int EPS_W = 22;
   localparam logic signed [EPS_W-1:0] EPS_Q30 = 22'sd1073742;
   localparam int DOT_DROP = 26;
   localparam int VEL_SHIFT = 34;

   typedef struct packed {
      logic       valid;
      logic       degenerate;
      logic [2:0] neg;
   } ctl_type;

   // round half away from zero on a right shift, sh >= 1
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x, input int sh);
      logic [63:0] m;
      m = x[63] ? 64'(-x) : 64'(x);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return x[63] ? -signed'(m) : signed'(m);
   endfunction

endpackage

/* sv/trc_front.sv */
module trc_front import trc_pkg::*; #(
   parameter int CB = 21
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ce,
   input  logic                    in_valid,
   input  logic [VEC_W-1:0]        vertex_a,
   input  logic [VEC_W-1:0]        vertex_b,
   input  logic [VEC_W-1:0]        vertex_c,
   input  logic [VEC_W-1:0]        hit_point,
   input  logic [VEC_W-1:0]        velocity_in,
   output ctl_type                 ctl_out,
   output logic [SUM_W-1:0]        sum_out,
   output logic [2:0][MAG_W-1:0]   mag_out,
   output logic [6*CB-1:0]         pv_out
);

   localparam int EW = CB + 1;
   localparam int PW = 2 * EW;
   localparam int NW = PW + 1;
   localparam int LEN_W = $clog2(NW + 1);
   localparam int STAGES = 8;
   localparam int PV_W = 6 * CB;

   ctl_type                  ctl_ff [STAGES];
   ctl_type                  ctl_in [STAGES];
   logic [PV_W-1:0]          pv_ff  [STAGES];
   logic signed [EW-1:0]     e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [PW-1:0]     pr_ff [6], pr_in [6];
   logic signed [NW-1:0]     n_ff [3], n_in [3];
   logic [NW-1:0]            mag_ff [3], mag_in [3];
   logic [NW-1:0]            magl_ff [3];
   logic [NW-1:0]            max_ff, max_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [MAG_W-1:0]         sm_ff [3], sm_in [3], sm2_ff [3], sm3_ff [3];
   logic [2*MAG_W-1:0]       sq_ff [3], sq_in [3];
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [NW-1:0]            max01;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EW'(signed'(vertex_b[i*CB +: CB])) - EW'(signed'(vertex_a[i*CB +: CB]));
         e2_in[i] = EW'(signed'(vertex_c[i*CB +: CB])) - EW'(signed'(vertex_a[i*CB +: CB]));
      end
      pr_in[0] = e1_ff[1] * e2_ff[2];
      pr_in[1] = e1_ff[2] * e2_ff[1];
      pr_in[2] = e1_ff[2] * e2_ff[0];
      pr_in[3] = e1_ff[0] * e2_ff[2];
      pr_in[4] = e1_ff[0] * e2_ff[1];
      pr_in[5] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(pr_ff[2*i]) - NW'(pr_ff[2*i+1]);
         mag_in[i] = n_ff[i][NW-1] ? NW'(-n_ff[i]) : NW'(n_ff[i]);
      end
      max01 = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      max_in = (max01 > mag_in[2]) ? max01 : mag_in[2];
      len_in = '0;
      for (int i = 0; i < NW; i++) begin
         if (max_ff[i]) begin
            len_in = LEN_W'(i + 1);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (len_ff > LEN_W'(UNIT_BITS)) begin
            sm_in[i] = MAG_W'(magl_ff[i] >> (len_ff - LEN_W'(UNIT_BITS)));
         end else begin
            sm_in[i] = MAG_W'(magl_ff[i] << (LEN_W'(UNIT_BITS) - len_ff));
         end
         sq_in[i] = sm_ff[i] * sm_ff[i];
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

      ctl_in[0] = '{valid: in_valid, degenerate: 1'b0, neg: 3'b000};
      for (int k = 1; k < STAGES; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[3].degenerate = (max_in == '0);
      ctl_in[3].neg = {n_ff[2][NW-1], n_ff[1][NW-1], n_ff[0][NW-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (ce) begin
         for (int k = 0; k < STAGES; k++) begin
            ctl_ff[k] <= ctl_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pv_ff[0] <= {velocity_in[3*CB-1:0], hit_point[3*CB-1:0]};
         for (int k = 1; k < STAGES; k++) begin
            pv_ff[k] <= pv_ff[k-1];
         end
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         pr_ff <= pr_in;
         n_ff <= n_in;
         mag_ff <= mag_in;
         max_ff <= max_in;
         magl_ff <= mag_ff;
         len_ff <= len_in;
         sm_ff <= sm_in;
         sq_ff <= sq_in;
         sm2_ff <= sm_ff;
         sum_ff <= sum_in;
         sm3_ff <= sm2_ff;
      end
   end

   assign ctl_out = ctl_ff[STAGES-1];
   assign sum_out = sum_ff;
   assign pv_out = pv_ff[STAGES-1];
   assign mag_out = {sm3_ff[2], sm3_ff[1], sm3_ff[0]};

   // a nonzero normal always lands with its largest magnitude at the top bit
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[5].valid && !ctl_ff[5].degenerate) |->
      (sm_ff[0][MAG_W-1] || sm_ff[1][MAG_W-1] || sm_ff[2][MAG_W-1]))
      else $error("normalized magnitude lost its top bit");

endmodule

/* sv/trc_sqrt.sv */
module trc_sqrt import trc_pkg::*; #(
   parameter int SIDE_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ce,
   input  ctl_type            ctl_in,
   input  logic [SUM_W-1:0]   sum_in,
   input  logic [SIDE_W-1:0]  side_in,
   output ctl_type            ctl_out,
   output logic [ROOT_W-1:0]  root_out,
   output logic [SIDE_W-1:0]  side_out
);

   localparam int STEPS = SUM_W / 2;
   localparam logic [SUM_W:0] ONE_TOP = (SUM_W+1)'(1) << (SUM_W - 2);

   ctl_type             ctl_ff  [STEPS];
   logic [SUM_W:0]      rem_ff  [STEPS], rem_in [STEPS], rem_src [STEPS];
   logic [SUM_W:0]      res_ff  [STEPS], res_in [STEPS], res_src [STEPS];
   logic [SIDE_W-1:0]   side_ff [STEPS];

   always_comb begin
      logic [SUM_W:0] one_v;
      logic [SUM_W:0] trial;
      rem_src[0] = {1'b0, sum_in};
      res_src[0] = '0;
      for (int k = 1; k < STEPS; k++) begin
         rem_src[k] = rem_ff[k-1];
         res_src[k] = res_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         one_v = ONE_TOP >> (2 * k);
         trial = res_src[k] + one_v;
         if (rem_src[k] >= trial) begin
            rem_in[k] = rem_src[k] - trial;
            res_in[k] = (res_src[k] >> 1) + one_v;
         end else begin
            rem_in[k] = rem_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (ce) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < STEPS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         side_ff[0] <= side_in;
         for (int k = 1; k < STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign ctl_out = ctl_ff[STEPS-1];
   assign root_out = res_ff[STEPS-1][ROOT_W-1:0];
   assign side_out = side_ff[STEPS-1];

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[STEPS-1].valid && !ctl_ff[STEPS-1].degenerate) |->
      (res_ff[STEPS-1][SUM_W:ROOT_W] == '0 &&
       (res_ff[STEPS-1][ROOT_W-1] || res_ff[STEPS-1][ROOT_W-2])))
      else $error("root out of range for a normalized sum");

endmodule

/* sv/trc_div.sv */
module trc_div import trc_pkg::*; #(
   parameter int SIDE_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ce,
   input  ctl_type                 ctl_in,
   input  logic [ROOT_W-1:0]       root_in,
   input  logic [2:0][MAG_W-1:0]   mag_in,
   input  logic [SIDE_W-1:0]       side_in,
   output ctl_type                 ctl_out,
   output logic [2:0][QUOT_W-1:0]  quo_out,
   output logic [SIDE_W-1:0]       side_out
);

   localparam int STEPS = QUOT_W;

   ctl_type              ctl_ff  [STEPS];
   logic [ROOT_W-1:0]    den_ff  [STEPS], den_src [STEPS];
   logic [ROOT_W-1:0]    rem_ff  [STEPS][3], rem_in [STEPS][3], rem_src [STEPS][3];
   logic [QUOT_W-1:0]    quo_ff  [STEPS][3], quo_in [STEPS][3], quo_src [STEPS][3];
   logic [SIDE_W-1:0]    side_ff [STEPS];

   always_comb begin
      logic [ROOT_W:0] trial;
      den_src[0] = root_in;
      for (int i = 0; i < 3; i++) begin
         rem_src[0][i] = ROOT_W'(mag_in[i] >> 1);
         quo_src[0][i] = '0;
      end
      for (int k = 1; k < STEPS; k++) begin
         den_src[k] = den_ff[k-1];
         rem_src[k] = rem_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         for (int i = 0; i < 3; i++) begin
            trial = {rem_src[k][i], (k == 0) ? mag_in[i][0] : 1'b0};
            if (trial >= {1'b0, den_src[k]}) begin
               rem_in[k][i] = ROOT_W'(trial - {1'b0, den_src[k]});
               quo_in[k][i] = {quo_src[k][i][QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[k][i] = ROOT_W'(trial);
               quo_in[k][i] = {quo_src[k][i][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (ce) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < STEPS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         den_ff <= den_src;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         side_ff[0] <= side_in;
         for (int k = 1; k < STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign ctl_out = ctl_ff[STEPS-1];
   assign quo_out = {quo_ff[STEPS-1][2], quo_ff[STEPS-1][1], quo_ff[STEPS-1][0]};
   assign side_out = side_ff[STEPS-1];

   // unit vector components never exceed one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[STEPS-1].valid && !ctl_ff[STEPS-1].degenerate) |->
      ((!quo_ff[STEPS-1][0][QUOT_W-1] || quo_ff[STEPS-1][0][QUOT_W-2:0] == '0) &&
       (!quo_ff[STEPS-1][1][QUOT_W-1] || quo_ff[STEPS-1][1][QUOT_W-2:0] == '0) &&
       (!quo_ff[STEPS-1][2][QUOT_W-1] || quo_ff[STEPS-1][2][QUOT_W-2:0] == '0)))
      else $error("unit vector component above one");

endmodule

/* sv/trc_reflect.sv */
module trc_reflect import trc_pkg::*; #(
   parameter int CB = 21,
   parameter int FB = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ce,
   input  ctl_type                 ctl_in,
   input  logic [2:0][QUOT_W-1:0]  quo_in,
   input  logic [6*CB-1:0]         pv_in,
   output logic                    out_valid,
   output logic [VEC_W-1:0]        position_out,
   output logic [VEC_W-1:0]        velocity_out,
   output logic                    degenerate
);

   localparam int STAGES = 6;
   localparam int PV_W = 6 * CB;
   localparam int UW = QUOT_W + 1;
   localparam int UV_W = UW + CB;
   localparam int UE_W = UW + EPS_W;
   localparam int DOT_W = UV_W + 2;
   localparam int OFF_W = CB + 1;
   localparam int D_W = DOT_W - DOT_DROP + 1;
   localparam int UD_W = UW + D_W;
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CB - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   function automatic logic [CB-1:0] sat_comp(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
      return CB'(y);
   endfunction

   ctl_type                ctl_ff [STAGES];
   logic [PV_W-1:0]        pv_ff  [STAGES];
   logic signed [UW-1:0]   u_ff [4][3], u_in [3];
   logic signed [UV_W-1:0] uv_ff [3], uv_in [3];
   logic signed [UE_W-1:0] ue_ff [3], ue_in [3];
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic signed [OFF_W-1:0] off_ff [3], off_in [3];
   logic signed [D_W-1:0]  d_ff, d_in;
   logic [CB-1:0]          pos_ff [3], pos_in [3], pos2_ff [3];
   logic signed [UD_W-1:0] ud_ff [3], ud_in [3];
   logic [3*CB-1:0]        opos_ff, opos_in, ovel_ff, ovel_in;
   logic                   odeg_ff;
   logic signed [CB-1:0]   pc [3], vc [3], vc4 [3];
   logic signed [63:0]     t [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = ctl_in.neg[i] ? -signed'({1'b0, quo_in[i]}) : signed'({1'b0, quo_in[i]});
         vc[i] = signed'(pv_ff[0][3*CB + i*CB +: CB]);
         uv_in[i] = u_ff[0][i] * vc[i];
         ue_in[i] = u_ff[0][i] * EPS_Q30;
         off_in[i] = OFF_W'(rnd_shift(64'(ue_ff[i]), 2 * UNIT_BITS - FB));
         pc[i] = signed'(pv_ff[2][i*CB +: CB]);
         pos_in[i] = sat_comp(64'(pc[i]) + 64'(off_ff[i]));
         ud_in[i] = u_ff[3][i] * d_ff;
         vc4[i] = signed'(pv_ff[4][3*CB + i*CB +: CB]);
         t[i] = (64'(vc4[i]) <<< VEL_SHIFT) - (64'(ud_ff[i]) <<< 1);
      end
      dot_in = DOT_W'(uv_ff[0]) + DOT_W'(uv_ff[1]) + DOT_W'(uv_ff[2]);
      d_in = D_W'(rnd_shift(64'(dot_ff), DOT_DROP));
      if (ctl_ff[4].degenerate) begin
         opos_in = pv_ff[4][3*CB-1:0];
         ovel_in = pv_ff[4][PV_W-1:3*CB];
      end else begin
         opos_in = {pos2_ff[2], pos2_ff[1], pos2_ff[0]};
         ovel_in = {sat_comp(rnd_shift(t[2], VEL_SHIFT)),
                    sat_comp(rnd_shift(t[1], VEL_SHIFT)),
                    sat_comp(rnd_shift(t[0], VEL_SHIFT))};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (ce) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < STAGES; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pv_ff[0] <= pv_in;
         for (int k = 1; k < STAGES; k++) begin
            pv_ff[k] <= pv_ff[k-1];
         end
         u_ff[0] <= u_in;
         for (int k = 1; k < 4; k++) begin
            u_ff[k] <= u_ff[k-1];
         end
         uv_ff <= uv_in;
         ue_ff <= ue_in;
         dot_ff <= dot_in;
         off_ff <= off_in;
         d_ff <= d_in;
         pos_ff <= pos_in;
         ud_ff <= ud_in;
         pos2_ff <= pos_ff;
         opos_ff <= opos_in;
         ovel_ff <= ovel_in;
         odeg_ff <= ctl_ff[4].degenerate;
      end
   end

   assign out_valid = ctl_ff[STAGES-1].valid;
   assign position_out = VEC_W'(opos_ff);
   assign velocity_out = VEC_W'(ovel_ff);
   assign degenerate = odeg_ff;

endmodule

/* sv/triangle_collision_reflect.sv */
// Specular reflection of a particle at a triangle: one collision record per
// transfer on req_, one result per record on rsp_, in order. The unit takes a
// new record every cycle unless the pipeline holds; each record passes through
// edges, cross product and normalization, then a digit-by-digit square root,
// then bit-serial division in three lanes, then dot product, offset and
// reflection. All stages advance together: when a result sits on rsp_ and
// rsp_tready is low the whole pipeline holds, otherwise it moves every cycle.
// A triangle with a zero normal sets rsp_tuser and returns the hit point and
// velocity unchanged.
module triangle_collision_reflect import trc_pkg::*; #(
   parameter int COMPONENT_BITS = 21,
   parameter int FRACTION_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_a, vertex_b, vertex_c, hit_point, velocity_in
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // position_out, velocity_out
   output logic [RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]       rsp_tuser
);

   localparam int CB = COMPONENT_BITS;
   localparam int PV_W = 6 * CB;
   localparam int SIDE_W = 3 * MAG_W + PV_W;

   logic                    ce;
   ctl_type                 f_ctl, s_ctl, d_ctl;
   logic [SUM_W-1:0]        f_sum;
   logic [2:0][MAG_W-1:0]   f_mag, s_mag;
   logic [PV_W-1:0]         f_pv, s_pv, d_pv;
   logic [SIDE_W-1:0]       s_side;
   logic [ROOT_W-1:0]       s_root;
   logic [2:0][QUOT_W-1:0]  d_quo;
   logic [VEC_W-1:0]        pos_out, vel_out;
   logic                    deg_out;

   assign ce = !rsp_tvalid || rsp_tready;
   assign req_tready = ce && !reset;

   trc_front #(.CB(CB)) u_front (
      .clock(clock), .reset(reset), .ce(ce), .in_valid(req_tvalid),
      .vertex_a(req_tdata[VEC_W-1:0]),
      .vertex_b(req_tdata[2*VEC_W-1:VEC_W]),
      .vertex_c(req_tdata[3*VEC_W-1:2*VEC_W]),
      .hit_point(req_tdata[4*VEC_W-1:3*VEC_W]),
      .velocity_in(req_tdata[5*VEC_W-1:4*VEC_W]),
      .ctl_out(f_ctl), .sum_out(f_sum), .mag_out(f_mag), .pv_out(f_pv)
   );

   trc_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
      .clock(clock), .reset(reset), .ce(ce),
      .ctl_in(f_ctl), .sum_in(f_sum), .side_in({f_pv, f_mag}),
      .ctl_out(s_ctl), .root_out(s_root), .side_out(s_side)
   );

   assign s_mag = s_side[3*MAG_W-1:0];
   assign s_pv = s_side[SIDE_W-1:3*MAG_W];

   trc_div #(.SIDE_W(PV_W)) u_div (
      .clock(clock), .reset(reset), .ce(ce),
      .ctl_in(s_ctl), .root_in(s_root), .mag_in(s_mag), .side_in(s_pv),
      .ctl_out(d_ctl), .quo_out(d_quo), .side_out(d_pv)
   );

   trc_reflect #(.CB(CB), .FB(FRACTION_BITS)) u_reflect (
      .clock(clock), .reset(reset), .ce(ce),
      .ctl_in(d_ctl), .quo_in(d_quo), .pv_in(d_pv),
      .out_valid(rsp_tvalid), .position_out(pos_out), .velocity_out(vel_out),
      .degenerate(deg_out)
   );

   assign rsp_tdata = {{(RSP_W - 2*VEC_W){1'b0}}, vel_out, pos_out};
   assign rsp_tuser = deg_out;

endmodule

/* test/triangle_collision_reflect_tb.sv */
`timescale 1ns / 1ps

module triangle_collision_reflect_tb;
   import trc_pkg::*;

   localparam int CB = 21;
   localparam int FB = 10;
   localparam longint EPS_FIX = 1073742;

   typedef struct {
      logic [VEC_W-1:0] position;
      logic [VEC_W-1:0] velocity;
      logic             degenerate;
   } reflect_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0]       rsp_tuser;

   reflect_type pending_q[$];
   int       errors = 0;
   int       sent = 0;
   int       received = 0;
   int       degenerate_seen = 0;
   int       burst_left = 0;
   int       stall_mode = 0;

   triangle_collision_reflect u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic longint comp_of(logic [VEC_W-1:0] v, int i);
      logic [CB-1:0] c;
      c = v[i*CB +: CB];
      return longint'(signed'(c));
   endfunction

   function automatic longint clamp(longint x);
      longint hi;
      hi = (longint'(1) << (CB - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic longint round_away(longint x, int sh);
      logic [63:0] m;
      m = x < 0 ? 64'(-x) : 64'(x);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic reflect_type predict_reflection(logic [REQ_W-1:0] rec);
      logic [VEC_W-1:0] va, vb, vc, hp, vi;
      longint a[3], e1[3], e2[3], n[3], p[3], v[3], u[3], pos[3], vel[3];
      logic [63:0] mag[3], m, s, r;
      longint dot, d, off, t;
      int len;
      reflect_type res;
      va = rec[0 +: VEC_W];
      vb = rec[VEC_W +: VEC_W];
      vc = rec[2*VEC_W +: VEC_W];
      hp = rec[3*VEC_W +: VEC_W];
      vi = rec[4*VEC_W +: VEC_W];
      for (int i = 0; i < 3; i++) begin
         a[i] = comp_of(va, i);
         e1[i] = comp_of(vb, i) - a[i];
         e2[i] = comp_of(vc, i) - a[i];
         p[i] = comp_of(hp, i);
         v[i] = comp_of(vi, i);
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
         if (mag[i] > m) m = mag[i];
      end
      res.position = '0;
      res.velocity = '0;
      if (m == 0) begin
         for (int i = 0; i < 3; i++) begin
            res.position[i*CB +: CB] = p[i][CB-1:0];
            res.velocity[i*CB +: CB] = v[i][CB-1:0];
         end
         res.degenerate = 1;
         return res;
      end
      len = 0;
      while (len < 64 && (m >> len) != 0) len++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (len > UNIT_BITS) mag[i] = mag[i] >> (len - UNIT_BITS);
         else mag[i] = mag[i] << (UNIT_BITS - len);
         s += mag[i] * mag[i];
      end
      r = int_sqrt(s);
      if (r == 0) r = 1;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'((mag[i] << UNIT_BITS) / r);
         if (n[i] < 0) u[i] = -u[i];
         dot += u[i] * v[i];
      end
      d = round_away(dot, DOT_DROP);
      for (int i = 0; i < 3; i++) begin
         off = round_away(u[i] * EPS_FIX, 2 * UNIT_BITS - FB);
         t = v[i] * (longint'(1) << VEL_SHIFT) - 2 * u[i] * d;
         pos[i] = clamp(p[i] + off);
         vel[i] = clamp(round_away(t, VEL_SHIFT));
         res.position[i*CB +: CB] = pos[i][CB-1:0];
         res.velocity[i*CB +: CB] = vel[i][CB-1:0];
      end
      res.degenerate = 0;
      return res;
   endfunction

   function automatic logic [VEC_W-1:0] pack_vec(longint x, longint y, longint z);
      logic [VEC_W-1:0] v;
      v = '0;
      v[0 +: CB] = x[CB-1:0];
      v[CB +: CB] = y[CB-1:0];
      v[2*CB +: CB] = z[CB-1:0];
      return v;
   endfunction

   function automatic logic [VEC_W-1:0] rand_vec();
      return VEC_W'({$urandom, $urandom});
   endfunction

   // small random component, from -span to span
   function automatic longint rand_comp(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   function automatic logic [VEC_W-1:0] small_vec(int span);
      return pack_vec(rand_comp(span), rand_comp(span), rand_comp(span));
   endfunction

   // one collision record per transfer, with random gaps between bursts
   task automatic send_record(logic [VEC_W-1:0] va, vb, vc, hp, vi);
      logic [REQ_W-1:0] rec;
      int gap;
      rec = '0;
      rec[0 +: VEC_W] = va;
      rec[VEC_W +: VEC_W] = vb;
      rec[2*VEC_W +: VEC_W] = vc;
      rec[3*VEC_W +: VEC_W] = hp;
      rec[4*VEC_W +: VEC_W] = vi;
      if (burst_left == 0) begin
         gap = $urandom_range(4);
         if (gap != 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= rec;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_q.push_back(predict_reflection(rec));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_extremes();
      logic [VEC_W-1:0] mx, mn;
      mx = pack_vec(1048575, 1048575, 1048575);
      mn = pack_vec(-1048576, -1048576, -1048576);
      send_record(pack_vec(0, 0, 0), pack_vec(1024, 0, 0), pack_vec(0, 1024, 0),
                  pack_vec(0, 0, 0), pack_vec(0, 0, -1024));
      send_record(mn, pack_vec(1048575, -1048576, -1048576),
                  pack_vec(-1048576, 1048575, -1048576), mx, mx);
      send_record(mn, pack_vec(1048575, -1048576, -1048576),
                  pack_vec(-1048576, 1048575, -1048576), mn, mn);
      send_record(pack_vec(0, 0, 0), pack_vec(1, 0, 0), pack_vec(0, 0, 1),
                  mx, pack_vec(0, 1048575, 0));
      send_record(pack_vec(0, 0, 0), pack_vec(1048575, 0, 0), pack_vec(0, -1048576, 0),
                  pack_vec(1048575, -1048576, 1048575), mn);
      send_record(pack_vec(5, 5, 5), pack_vec(7, 3, 5), pack_vec(5, 9, 1),
                  pack_vec(100, -100, 0), pack_vec(-512, 300, 77));
      // random first vertex
      send_record(rand_vec(), pack_vec(3, 1, 2), pack_vec(-7, 9, 4),
                  pack_vec(1, 2, 3), pack_vec(1, -1, 1));
   endtask

   task automatic test_degenerate();
      logic [VEC_W-1:0] pt;
      pt = rand_vec();
      send_record(pt, pt, pt, rand_vec(), rand_vec());
      send_record(pack_vec(0, 0, 0), pack_vec(10, 20, 30), pack_vec(-5, -10, -15),
                  pack_vec(1048575, -1048576, 0), pack_vec(-1048576, 1048575, 1));
      send_record(pack_vec(1, 1, 1), pack_vec(2, 2, 2), pack_vec(100, 100, 100),
                  rand_vec(), rand_vec());
      send_record(rand_vec(), rand_vec(), pack_vec(0, 0, 0), rand_vec(), rand_vec());
      drain_results();
   endtask

   task automatic test_random_records(int count);
      logic [VEC_W-1:0] a, p;
      int kind;
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(9);
         if (kind < 5) begin
            a = small_vec(4000);
            send_record(a, small_vec(4000), small_vec(4000), small_vec(4000),
                        small_vec(4000));
         end else if (kind < 8) begin
            send_record(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec());
         end else if (kind == 8) begin
            a = rand_vec();
            p = rand_vec();
            send_record(a, a, rand_vec(), p, rand_vec());
         end else begin
            send_record(small_vec(3), small_vec(3), small_vec(3), rand_vec(), rand_vec());
         end
         if (k == count / 2) drain_results();
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if ($urandom_range(199) == 0) stall_mode = $urandom_range(3);
         case (stall_mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= $urandom_range(1);
            2: rsp_tready <= ($urandom_range(9) != 0);
            default: rsp_tready <= ($urandom_range(9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      reflect_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (rsp_tuser[0]) degenerate_seen++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected transfer, actual pos %h vel %h flag %b", $time,
                     rsp_tdata[0 +: VEC_W], rsp_tdata[VEC_W +: VEC_W], rsp_tuser[0]);
            errors++;
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_tdata[0 +: VEC_W] !== exp_r.position) begin
               $display("%0t: position_out expected %h actual %h", $time,
                        exp_r.position, rsp_tdata[0 +: VEC_W]);
               errors++;
            end
            if (rsp_tdata[VEC_W +: VEC_W] !== exp_r.velocity) begin
               $display("%0t: velocity_out expected %h actual %h", $time,
                        exp_r.velocity, rsp_tdata[VEC_W +: VEC_W]);
               errors++;
            end
            if (rsp_tuser[0] !== exp_r.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time,
                        exp_r.degenerate, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("triangle_collision_reflect test failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_extremes();
      test_degenerate();
      test_random_records(790);
      drain_results();
      repeat (200) @(negedge clock);
      $display("records sent %0d, results checked %0d, degenerate %0d", sent, received,
               degenerate_seen);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("triangle_collision_reflect test passed");
      end else begin
         $display("triangle_collision_reflect test failed");
      end
      $finish;
   end

endmodule
